>>> rtl/tga_rle_pixel_decoder_assert.svh
// ----------------------------------------------------------------------------
// TGA RLE pixel decoder assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TGA_RLE_PIXEL_DECODER_ASSERT_SVH
`define TGA_RLE_PIXEL_DECODER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TGARLE_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TGARLE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/tgarle_pkg.sv
// ----------------------------------------------------------------------------
// TGA RLE pixel decoder package
// Shared types, packet header constants and depth decoding.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tgarle_pkg;

  localparam logic [7:0] HDR_COUNT_MASK = 8'h7F;
  localparam logic [7:0] HDR_REPEAT_BIT = 8'h80;
  localparam logic [7:0] TOP5_MASK      = 8'hF8;

  // Effective depth minus one: 0 = 1 byte, 3 = 4 bytes.
  localparam logic [1:0] DEPTH_1 = 2'd0;
  localparam logic [1:0] DEPTH_2 = 2'd1;
  localparam logic [1:0] DEPTH_3 = 2'd2;
  localparam logic [1:0] DEPTH_4 = 2'd3;

  localparam logic CFG_IDX_BYTES_PER_PIXEL = 1'b0;
  localparam logic CFG_IDX_COMPRESSED      = 1'b1;

  typedef struct packed {
    logic [1:0] depth_m1;
    logic       compressed;
  } cfg_t;

  typedef struct packed {
    logic [23:0] pixel;
    logic [1:0]  depth_m1;
    logic [7:0]  reps;
  } pix_item_t;

  // Out-of-range depths saturate: 0 acts as 1, 5..7 act as 4.
  function automatic logic [1:0] eff_depth_m1(input logic [2:0] bpp);
    logic [1:0] d;
    if (bpp == 3'd0) begin
      d = DEPTH_1;
    end else if (bpp > 3'd4) begin
      d = DEPTH_4;
    end else begin
      d = 2'(bpp - 3'd1);
    end
    return d;
  endfunction

endpackage

>>> rtl/tgarle_in_if.sv
// ----------------------------------------------------------------------------
// TGA RLE byte input channel
// Valid/ready channel carrying one encoded stream byte per item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tgarle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

>>> rtl/tgarle_out_if.sv
// ----------------------------------------------------------------------------
// TGA RLE pixel output channel
// Valid/ready channel carrying one converted pixel and its repeat count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tgarle_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte_first;
  logic [7:0] out_byte_second;
  logic [7:0] out_byte_third;
  logic [1:0] valid_bytes;
  logic [7:0] repeat_count;

  modport source (output valid, output out_byte_first, output out_byte_second,
                  output out_byte_third, output valid_bytes, output repeat_count,
                  input ready);
  modport sink   (input valid, input out_byte_first, input out_byte_second,
                  input out_byte_third, input valid_bytes, input repeat_count,
                  output ready);
endinterface

>>> rtl/tga_rle_pixel_decoder.sv
// ----------------------------------------------------------------------------
// TGA RLE pixel decoder
// Decodes raw or run-length TGA byte streams into converted pixels with
// repeat counts.
// ----------------------------------------------------------------------------
// Channel     Dir  Payload                                      Item
// byte_in     in   data_byte[7:0]                               one stream byte
// pixel_out   out  out_byte_first/second/third, valid_bytes,    one pixel
//                  repeat_count
// cfg_wr_*    in   cfg_index[0], cfg_wr_data[2:0]               register write
//
// One byte is taken every cycle unless a stall on pixel_out backs up; a
// completed pixel reaches pixel_out through the parser register, then the
// output register. The parser's packet state is updated once per byte.
// Reset selects 3 bytes per pixel, compressed input, header expected.
// A stall on pixel_out fills the two registers before byte_in drops ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tga_rle_pixel_decoder (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wr_en,
  input  logic         cfg_index,
  input  logic [2:0]   cfg_wr_data,
  tgarle_in_if.sink    byte_in,
  tgarle_out_if.source pixel_out
);

  logic [2:0]            bytes_per_pixel;
  logic                  compressed;
  tgarle_pkg::cfg_t      cfg;
  logic                  item_valid;
  logic                  item_ready;
  tgarle_pkg::pix_item_t item;

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_per_pixel <= 3'd3;
      compressed      <= 1'b1;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        tgarle_pkg::CFG_IDX_BYTES_PER_PIXEL: bytes_per_pixel <= cfg_wr_data;
        tgarle_pkg::CFG_IDX_COMPRESSED:      compressed      <= cfg_wr_data[0];
        default: ;
      endcase
    end
  end

  assign cfg.depth_m1   = tgarle_pkg::eff_depth_m1(bytes_per_pixel);
  assign cfg.compressed = compressed;

  tgarle_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (byte_in.valid),
    .in_ready   (byte_in.ready),
    .in_byte    (byte_in.data_byte),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item)
  );

  tgarle_convert u_convert (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .pixel_out  (pixel_out)
  );

endmodule

>>> rtl/tgarle_parser.sv
// ----------------------------------------------------------------------------
// TGA RLE packet parser
// Tracks packet headers, assembles stored pixel bytes and registers each
// completed pixel with its repeat count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tgarle_parser (
  input  logic                 clk,
  input  logic                 rst,
  input  tgarle_pkg::cfg_t     cfg,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_byte,
  output logic                 item_valid,
  input  logic                 item_ready,
  output tgarle_pkg::pix_item_t item
);

  logic        expect_header, expect_header_next;
  logic [7:0]  packet_remaining, packet_remaining_next;
  logic        literal_packet, literal_packet_next;
  logic [1:0]  byte_position, byte_position_next;
  logic [23:0] pixel_collect, pixel_collect_next;
  logic        emit;
  logic [7:0]  reps;
  logic        in_fire;

  assign in_ready = !item_valid || item_ready;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    expect_header_next    = expect_header;
    packet_remaining_next = packet_remaining;
    literal_packet_next   = literal_packet;
    byte_position_next    = byte_position;
    pixel_collect_next    = pixel_collect;
    emit                  = 1'b0;
    reps                  = 8'd1;
    if (in_fire) begin
      if (cfg.compressed && expect_header) begin
        packet_remaining_next = (in_byte & tgarle_pkg::HDR_COUNT_MASK) + 8'd1;
        literal_packet_next   = ((in_byte & tgarle_pkg::HDR_REPEAT_BIT) == 8'd0);
        expect_header_next    = 1'b0;
        byte_position_next    = 2'd0;
      end else begin
        unique case (byte_position)
          2'd0:    pixel_collect_next[7:0]   = in_byte;
          2'd1:    pixel_collect_next[15:8]  = in_byte;
          2'd2:    pixel_collect_next[23:16] = in_byte;
          default: ;  // The alpha byte of a 4-byte pixel is not kept.
        endcase
        if (byte_position < cfg.depth_m1) begin
          byte_position_next = byte_position + 2'd1;
        end else begin
          byte_position_next = 2'd0;
          emit               = 1'b1;
          if (cfg.compressed) begin
            if (literal_packet) begin
              packet_remaining_next = packet_remaining - 8'd1;
              if (packet_remaining_next == 8'd0) begin
                expect_header_next = 1'b1;
              end
            end else begin
              reps                  = packet_remaining;
              packet_remaining_next = 8'd0;
              expect_header_next    = 1'b1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expect_header    <= 1'b1;
      packet_remaining <= 8'd0;
      literal_packet   <= 1'b0;
      byte_position    <= 2'd0;
      pixel_collect    <= 24'd0;
      item_valid       <= 1'b0;
    end else begin
      expect_header    <= expect_header_next;
      packet_remaining <= packet_remaining_next;
      literal_packet   <= literal_packet_next;
      byte_position    <= byte_position_next;
      pixel_collect    <= pixel_collect_next;
      if (in_ready) begin
        item_valid <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      item.pixel    <= pixel_collect_next;
      item.depth_m1 <= cfg.depth_m1;
      item.reps     <= reps;
    end
  end

`include "tga_rle_pixel_decoder_assert.svh"

  `TGARLE_ASSERT_SAME(a_open_packet_nonempty, !expect_header, packet_remaining != 8'd0, "open packet has no pixels left")
  `TGARLE_ASSERT_NEXT(a_header_opens_packet, in_fire && cfg.compressed && expect_header, !expect_header && byte_position == 2'd0, "header byte did not open a packet")
  `TGARLE_ASSERT_SAME(a_item_reps_range, item_valid, item.reps != 8'd0 && item.reps <= 8'd128, "repeat count out of range")

endmodule

>>> rtl/tgarle_convert.sv
// ----------------------------------------------------------------------------
// TGA RLE pixel converter
// Converts an assembled pixel to output bytes by depth and holds the result
// in the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tgarle_convert (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  tgarle_pkg::pix_item_t item,
  tgarle_out_if.source          pixel_out
);

  logic [7:0]  b0, b1, b2;
  logic [15:0] v;
  logic [7:0]  first_c, second_c, third_c;
  logic [1:0]  nbytes_c;

  assign b0 = item.pixel[7:0];
  assign b1 = item.pixel[15:8];
  assign b2 = item.pixel[23:16];
  assign v  = {b1, b0};

  assign item_ready = !pixel_out.valid || pixel_out.ready;

  always_comb begin
    nbytes_c = 2'd3;
    unique case (item.depth_m1)
      tgarle_pkg::DEPTH_1: begin
        first_c  = b0;
        second_c = 8'd0;
        third_c  = 8'd0;
        nbytes_c = 2'd1;
      end
      tgarle_pkg::DEPTH_2: begin
        // 5-5-5 fields land in the top bits of each byte.
        first_c  = 8'(v >> 7) & tgarle_pkg::TOP5_MASK;
        second_c = 8'(v >> 2) & tgarle_pkg::TOP5_MASK;
        third_c  = 8'(v << 3) & tgarle_pkg::TOP5_MASK;
      end
      tgarle_pkg::DEPTH_3: begin
        first_c  = b0;
        second_c = b1;
        third_c  = b2;
      end
      default: begin
        first_c  = b2;
        second_c = b1;
        third_c  = b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_out.valid <= 1'b0;
    end else if (item_ready) begin
      pixel_out.valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      pixel_out.out_byte_first  <= first_c;
      pixel_out.out_byte_second <= second_c;
      pixel_out.out_byte_third  <= third_c;
      pixel_out.valid_bytes     <= nbytes_c;
      pixel_out.repeat_count    <= item.reps;
    end
  end

`include "tga_rle_pixel_decoder_assert.svh"

  `TGARLE_ASSERT_SAME(a_single_byte_zeros, pixel_out.valid && pixel_out.valid_bytes == 2'd1, pixel_out.out_byte_second == 8'd0 && pixel_out.out_byte_third == 8'd0, "unused output bytes not zero")
  `TGARLE_ASSERT_NEXT(a_drain_empties, pixel_out.valid && pixel_out.ready && !item_valid, !pixel_out.valid, "output stayed valid after drain")
  `TGARLE_ASSERT_NEXT(a_load_sets_valid, item_valid && item_ready, pixel_out.valid, "accepted item did not reach output")

endmodule

>>> tb/sv/tb_tgarle_pkg.sv
// ----------------------------------------------------------------------------
// TGA RLE pixel decoder scoreboard
// Predicts converted pixels from accepted stream bytes and checks each
// pixel that leaves the decoder against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tb_tgarle_pkg;

  import tgarle_pkg::*;

  typedef struct packed {
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [1:0] nbytes;
    logic [7:0] reps;
  } pixel_t;

  class tga_pixel_checker;
    logic [2:0]  bpp;
    logic        comp;
    logic        want_header;
    logic [7:0]  run_left;
    logic        literal;
    logic [1:0]  pos;
    logic [23:0] collect;
    pixel_t      pending_pixels[$];
    int unsigned errors;

    function new();
      bpp         = 3'd3;
      comp        = 1'b1;
      want_header = 1'b1;
      run_left    = 8'd0;
      literal     = 1'b0;
      pos         = 2'd0;
      collect     = 24'd0;
      errors      = 0;
    endfunction

    function automatic logic [1:0] depth_code();
      if (bpp == 3'd0) begin
        return DEPTH_1;
      end
      if (bpp > 3'd4) begin
        return DEPTH_4;
      end
      return 2'(bpp - 3'd1);
    endfunction

    // Advances the decode state by one accepted byte and queues the pixel
    // that it completes, if any.
    function void decode_byte(logic [7:0] b);
      logic [1:0]  dm;
      logic [7:0]  reps;
      logic [15:0] v;
      pixel_t      px;
      dm = depth_code();
      if (comp && want_header) begin
        run_left    = (b & HDR_COUNT_MASK) + 8'd1;
        literal     = ((b & HDR_REPEAT_BIT) == 8'd0);
        want_header = 1'b0;
        pos         = 2'd0;
        return;
      end
      if (pos != 2'd3) begin
        collect[8*pos +: 8] = b;
      end
      // A pixel is done once the position reaches the last byte of the
      // current depth, even if the depth shrank while collecting.
      if (pos < dm) begin
        pos = pos + 2'd1;
        return;
      end
      pos = 2'd0;
      if (!comp) begin
        reps = 8'd1;
      end else if (literal) begin
        reps     = 8'd1;
        run_left = run_left - 8'd1;
        if (run_left == 8'd0) begin
          want_header = 1'b1;
        end
      end else begin
        reps        = run_left;
        run_left    = 8'd0;
        want_header = 1'b1;
      end
      case (dm)
        DEPTH_1: begin
          px.byte0  = collect[7:0];
          px.byte1  = 8'd0;
          px.byte2  = 8'd0;
          px.nbytes = 2'd1;
        end
        DEPTH_2: begin
          v         = collect[15:0];
          px.byte0  = 8'(v >> 7) & TOP5_MASK;
          px.byte1  = 8'(v >> 2) & TOP5_MASK;
          px.byte2  = 8'(v << 3) & TOP5_MASK;
          px.nbytes = 2'd3;
        end
        DEPTH_3: begin
          px.byte0  = collect[7:0];
          px.byte1  = collect[15:8];
          px.byte2  = collect[23:16];
          px.nbytes = 2'd3;
        end
        default: begin
          px.byte0  = collect[23:16];
          px.byte1  = collect[15:8];
          px.byte2  = collect[7:0];
          px.nbytes = 2'd3;
        end
      endcase
      px.reps = reps;
      pending_pixels.push_back(px);
    endfunction

    task report(string what);
      $display("[%0t] mismatch: %s", $time, what);
      errors++;
    endtask

    task match_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want) begin
        report($sformatf("%s got %0h, expected %0h", name, got, want));
      end
    endtask

    task check_pixel(pixel_t got);
      pixel_t want;
      if (pending_pixels.size() == 0) begin
        report($sformatf("pixel %h arrived with nothing expected", got));
        return;
      end
      want = pending_pixels.pop_front();
      match_field("out_byte_first", got.byte0, want.byte0);
      match_field("out_byte_second", got.byte1, want.byte1);
      match_field("out_byte_third", got.byte2, want.byte2);
      match_field("valid_bytes", 8'(got.nbytes), 8'(want.nbytes));
      match_field("repeat_count", got.reps, want.reps);
    endtask
  endclass

endpackage

>>> tb/sv/tb_tga_rle_pixel_decoder.sv
// ----------------------------------------------------------------------------
// TGA RLE pixel decoder testbench
// Drives directed and random byte streams, raw and run-length, across many
// depth settings with random stalls on both channels, and checks every
// pixel against a scoreboard prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_tga_rle_pixel_decoder;

  import tgarle_pkg::*;
  import tb_tgarle_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned RANDOM_ITEMS = 1650;

  logic       clk;
  logic       rst;
  logic       cfg_wr_en;
  logic       cfg_index;
  logic [2:0] cfg_wr_data;

  tgarle_in_if  byte_in ();
  tgarle_out_if pixel_out ();

  tga_rle_pixel_decoder u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .byte_in     (byte_in),
    .pixel_out   (pixel_out)
  );

  tga_pixel_checker sb = new();

  int unsigned cycles;
  int unsigned bytes_sent;
  bit          in_calm;
  bit          out_calm;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic int unsigned draw_gap(bit calm);
    return calm ? 0 : $urandom_range(0, 4);
  endfunction

  // Valid is only lowered when a gap follows, so it never gets two
  // assignments in one step.
  task send_byte(logic [7:0] b);
    int unsigned gap;
    gap = draw_gap(in_calm);
    if (gap > 0) begin
      byte_in.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_in.valid     <= 1'b1;
    byte_in.data_byte <= b;
    do @(posedge clk); while (!byte_in.ready);
    sb.decode_byte(b);
    bytes_sent++;
  endtask

  task play(logic [7:0] seq[$]);
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  // Drains every expected pixel, then leaves time for the pipeline to empty.
  task settle();
    byte_in.valid <= 1'b0;
    while (sb.pending_pixels.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task write_reg(logic idx, logic [2:0] data);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= idx;
    cfg_wr_data <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    if (idx == CFG_IDX_BYTES_PER_PIXEL) begin
      sb.bpp = data;
    end else begin
      sb.comp = data[0];
    end
  endtask

  task write_depth(logic [2:0] bpp);
    write_reg(CFG_IDX_BYTES_PER_PIXEL, bpp);
  endtask

  task write_mode(logic comp);
    write_reg(CFG_IDX_COMPRESSED, {2'($urandom), comp});
  endtask

  // Headers follow the scoreboard's model of the packet state, so most of the stream is
  // well-formed packets; a few bytes are drawn with no regard to it.
  function automatic logic [7:0] next_byte();
    int unsigned r;
    int unsigned cnt;
    if ($urandom_range(0, 19) == 0) begin
      return 8'($urandom);
    end
    if (sb.comp && sb.want_header) begin
      r = $urandom_range(0, 9);
      if (r < 6) begin
        cnt = $urandom_range(0, 3);
      end else if (r < 9) begin
        cnt = $urandom_range(4, 15);
      end else begin
        cnt = $urandom_range(16, 127);
      end
      return {1'($urandom), 7'(cnt)};
    end
    r = $urandom_range(0, 7);
    if (r == 0) begin
      return 8'h00;
    end
    if (r == 1) begin
      return 8'hFF;
    end
    return 8'($urandom);
  endfunction

  initial begin
    pixel_out.ready = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      int unsigned gap;
      pixel_t      got;
      gap = draw_gap(out_calm);
      if (gap > 0) begin
        pixel_out.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pixel_out.ready <= 1'b1;
      do @(posedge clk); while (!pixel_out.valid);
      got.byte0  = pixel_out.out_byte_first;
      got.byte1  = pixel_out.out_byte_second;
      got.byte2  = pixel_out.out_byte_third;
      got.nbytes = pixel_out.valid_bytes;
      got.reps   = pixel_out.repeat_count;
      sb.check_pixel(got);
    end
  end

  initial begin
    logic [7:0]  seq[$];
    int unsigned target;
    int unsigned n;
    rst               = 1'b1;
    cfg_wr_en         = 1'b0;
    cfg_index         = 1'b0;
    cfg_wr_data       = 3'd0;
    byte_in.valid     = 1'b0;
    byte_in.data_byte = 8'd0;
    cycles            = 0;
    bytes_sent        = 0;
    in_calm           = 1'b0;
    out_calm          = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: a full-length run, a one-pixel literal packet, then a
    // run of one left with one byte of its pixel collected.
    seq = {8'hFF, 8'h00, 8'hFF, 8'h80, 8'h00, 8'h12, 8'h34, 8'h56, 8'h80, 8'hAA};
    play(seq);
    settle();
    // Depth zero acts as one byte and completes the pending pixel at once.
    write_depth(3'd0);
    seq = {8'h55, 8'h01, 8'hFF, 8'h00};
    play(seq);
    settle();
    // Raw 555 pixels at both extremes.
    write_depth(3'd2);
    write_mode(1'b0);
    seq = {8'hFF, 8'h7F, 8'h00, 8'h80};
    play(seq);
    settle();
    // Depth seven saturates to four bytes with alpha dropped.
    write_depth(3'd7);
    write_mode(1'b1);
    seq = {8'h81, 8'h01, 8'h02, 8'h03, 8'hFF};
    play(seq);

    target = bytes_sent + RANDOM_ITEMS;
    while (bytes_sent < target) begin
      settle();
      if ($urandom_range(0, 3) != 0) begin
        if ($urandom_range(0, 9) < 7) begin
          write_depth(3'($urandom_range(1, 4)));
        end else begin
          write_depth(3'($urandom_range(0, 7)));
        end
      end
      if ($urandom_range(0, 3) != 0) begin
        write_mode($urandom_range(0, 3) != 0);
      end
      in_calm  = ($urandom_range(0, 4) == 0);
      out_calm = ($urandom_range(0, 4) == 0);
      n = $urandom_range(10, 120);
      repeat (n) send_byte(next_byte());
    end

    settle();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending_pixels.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
